// ----- design/waypoint_follow_steering_defines.svh -----
// Assertion macros for the waypoint steering block.
`ifndef WAYPOINT_FOLLOW_STEERING_DEFINES_SVH
`define WAYPOINT_FOLLOW_STEERING_DEFINES_SVH

`ifndef SYNTH
`define WFS_ASSERT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("wfs check failed");
`define WFS_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("wfs check failed");
`else
`define WFS_ASSERT(lbl, a, b)
`define WFS_ASSERT_NEXT(lbl, a, b)
`endif

`endif

// ----- design/wfs_pkg.sv -----
// Shared types, widths and the arctangent table of the waypoint steering block.
package wfs_pkg;

  localparam int unsigned POS_W    = 24;
  localparam int unsigned CORDIC_W = 44;
  localparam int unsigned ANG_W    = 18;
  localparam int unsigned MUL_A_W  = 37;
  localparam int unsigned MUL_B_W  = 26;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SQ_W     = 50;
  localparam int unsigned ATAN_W   = 14;

  localparam logic [2:0] CFG_STEER_GAIN   = 3'd0;
  localparam logic [2:0] CFG_STEER_LIMIT  = 3'd1;
  localparam logic [2:0] CFG_REACH_RADIUS = 3'd2;
  localparam logic [2:0] CFG_MIN_MOVE     = 3'd3;
  localparam logic [2:0] CFG_CRUISE_SPEED = 3'd4;

  localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(16384);

  typedef struct packed {
    logic load;
    logic step;
    logic vectoring;
  } wfs_cordic_ctrl_t;

  function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 14'd8192;
      5'd1:    v = 14'd4836;
      5'd2:    v = 14'd2555;
      5'd3:    v = 14'd1297;
      5'd4:    v = 14'd651;
      5'd5:    v = 14'd326;
      5'd6:    v = 14'd163;
      5'd7:    v = 14'd81;
      5'd8:    v = 14'd41;
      5'd9:    v = 14'd20;
      5'd10:   v = 14'd10;
      5'd11:   v = 14'd5;
      5'd12:   v = 14'd3;
      5'd13:   v = 14'd1;
      5'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/waypoint_follow_steering.sv -----
// Waypoint path follower with proportional cross-track steering, top level.
//
// Input channel (in_valid_i/in_ready_o) carries one word per item: kind_i 0
// stores a waypoint at waypoint_index_i (last_waypoint_i sets the path length),
// kind_i 1 is a vehicle position sample. A load gives no result. A sample gives
// one result word on out_valid_o/out_ready_i. A sample passes through the
// shared multiplier and the iterative CORDIC; each waypoint passed adds a read
// of the next one, and the vectoring pass is skipped when the heading is held.
// The input is not ready while a sample is in progress and is ready again in
// the cycle its result appears in the output register.
// The output register holds a result until taken; a new sample may be taken
// meanwhile, and its result waits in the final state while the receiver stalls.
// Configuration words (cfg_valid_i, cfg_addr_i, cfg_data_i) are always taken;
// write them only while the block is idle.
// Reset clears configuration to defaults, path length, target and previous heading;
// waypoint storage is undefined until loaded. No clearing pass is needed.
`include "waypoint_follow_steering_defines.svh"
module waypoint_follow_steering import wfs_pkg::*; #(
  parameter int unsigned PATH_DEPTH   = 1024,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [9:0]         waypoint_index_i,
  input  logic               last_waypoint_i,
  input  logic signed [23:0] x_pos_i,
  input  logic signed [23:0] y_pos_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [18:0] steer_cmd_o,
  output logic [15:0]        speed_cmd_o,
  output logic [9:0]         target_index_o,
  output logic signed [15:0] heading_o,
  output logic signed [24:0] lateral_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_addr_i,
  input  logic [17:0]        cfg_data_i
);

  localparam int unsigned AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_R2   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_MM   = 5'd3;
  localparam logic [4:0] S_ADV  = 5'd4;
  localparam logic [4:0] S_DY   = 5'd5;
  localparam logic [4:0] S_CMP  = 5'd6;
  localparam logic [4:0] S_RD   = 5'd7;
  localparam logic [4:0] S_MX   = 5'd8;
  localparam logic [4:0] S_MY   = 5'd9;
  localparam logic [4:0] S_MCMP = 5'd10;
  localparam logic [4:0] S_VEC  = 5'd11;
  localparam logic [4:0] S_VEND = 5'd12;
  localparam logic [4:0] S_ROTI = 5'd13;
  localparam logic [4:0] S_ROT  = 5'd14;
  localparam logic [4:0] S_LAT  = 5'd15;
  localparam logic [4:0] S_LS   = 5'd16;
  localparam logic [4:0] S_ST   = 5'd17;
  localparam logic [4:0] S_STC  = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  localparam logic signed [MUL_B_W-1:0] LAT_RECIP = MUL_B_W'(39797);
  localparam logic signed [MUL_P_W-1:0] LAT_RND   = MUL_P_W'(8388608);
  localparam logic signed [MUL_P_W-1:0] LAT_MAX   = MUL_P_W'(16777215);
  localparam logic signed [MUL_P_W-1:0] LAT_MIN   = -MUL_P_W'(16777216);
  localparam logic signed [MUL_P_W-1:0] STEER_RND = MUL_P_W'(8);
  localparam logic [4:0]                LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic [4:0]  state_q, state_d, cnt_q, cnt_d;
  logic [11:0] gain_q;
  logic [17:0] limit_q;
  logic [15:0] reach_q, min_q, speed_q;
  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d, tx_q, tx_d, ty_q, ty_d;
  logic signed [POS_W-1:0] prevx_q, prevx_d, prevy_q, prevy_d;
  logic signed [15:0] prevh_q, prevh_d, head_q, head_d;
  logic [9:0]  slot_q, slot_d;
  logic [10:0] len_q, len_d;
  logic        rdy_q, rdy_d;
  logic [31:0] r2_q, r2_d, mm2_q, mm2_d;
  logic [SQ_W-1:0] acc_q, acc_d, sum_sq;
  logic signed [24:0] lat_q, lat_d;
  logic signed [18:0] steer_q, steer_d;
  logic        ovalid_q, ovalid_d;
  logic signed [18:0] osteer_q, osteer_d;
  logic [15:0] ospeed_q, ospeed_d;
  logic [9:0]  oslot_q, oslot_d;
  logic signed [15:0] ohead_q, ohead_d;
  logic signed [24:0] olat_q, olat_d;

  logic signed [POS_W:0] dx, dy, mx, my;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p, lat_full, steer_full, lim;
  wfs_cordic_ctrl_t cctl;
  logic signed [CORDIC_W-1:0] cx_in, cy_in, cx, cy;
  logic signed [ANG_W-1:0] cz_in, cz;
  logic        in_acc, adv_ok, mem_we, mem_re;
  logic [2*POS_W-1:0] mem_rdata;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  assign dx = (POS_W+1)'(tx_q) - (POS_W+1)'(px_q);
  assign dy = (POS_W+1)'(ty_q) - (POS_W+1)'(py_q);
  assign mx = (POS_W+1)'(px_q) - (POS_W+1)'(prevx_q);
  assign my = (POS_W+1)'(py_q) - (POS_W+1)'(prevy_q);

  assign sum_sq = acc_q + mul_p[SQ_W-1:0];
  assign adv_ok = rdy_q && ((11'(slot_q) + 11'd1) < len_q)
                  && ((32'(slot_q) + 32'd1) < 32'(PATH_DEPTH));
  assign lat_full   = (mul_p + LAT_RND) >>> 24;
  assign steer_full = (mul_p + STEER_RND) >>> 4;
  assign lim        = $signed(MUL_P_W'(limit_q));

  assign mem_we = in_acc && !kind_i && (32'(waypoint_index_i) < 32'(PATH_DEPTH));
  assign mem_re = (state_q == S_CMP);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_R2: begin
        mul_a = MUL_A_W'(reach_q);
        mul_b = MUL_B_W'(reach_q);
      end
      S_M2: begin
        mul_a = MUL_A_W'(min_q);
        mul_b = MUL_B_W'(min_q);
      end
      S_ADV: begin
        mul_a = MUL_A_W'(dx);
        mul_b = MUL_B_W'(dx);
      end
      S_DY: begin
        mul_a = MUL_A_W'(dy);
        mul_b = MUL_B_W'(dy);
      end
      S_MX: begin
        mul_a = MUL_A_W'(mx);
        mul_b = MUL_B_W'(mx);
      end
      S_MY: begin
        mul_a = MUL_A_W'(my);
        mul_b = MUL_B_W'(my);
      end
      S_LAT: begin
        mul_a = MUL_A_W'(cy);
        mul_b = LAT_RECIP;
      end
      S_ST: begin
        mul_a = MUL_A_W'(lat_q);
        mul_b = MUL_B_W'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    cctl.load      = (state_q == S_MCMP) || (state_q == S_ROTI);
    cctl.step      = (state_q == S_VEC) || (state_q == S_ROT);
    cctl.vectoring = (state_q == S_MCMP) || (state_q == S_VEC);
    if (state_q == S_MCMP) begin
      cx_in = CORDIC_W'(mx) <<< 16;
      cy_in = CORDIC_W'(my) <<< 16;
    end else begin
      cx_in = CORDIC_W'(dx) <<< 8;
      cy_in = CORDIC_W'(dy) <<< 8;
    end
    cz_in = -ANG_W'(head_q);
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    px_d     = px_q;
    py_d     = py_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    prevx_d  = prevx_q;
    prevy_d  = prevy_q;
    prevh_d  = prevh_q;
    head_d   = head_q;
    slot_d   = slot_q;
    len_d    = len_q;
    rdy_d    = rdy_q;
    r2_d     = r2_q;
    mm2_d    = mm2_q;
    acc_d    = acc_q;
    lat_d    = lat_q;
    steer_d  = steer_q;
    ovalid_d = ovalid_q && !out_ready_i;
    osteer_d = osteer_q;
    ospeed_d = ospeed_q;
    oslot_d  = oslot_q;
    ohead_d  = ohead_q;
    olat_d   = olat_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i) begin
            px_d    = x_pos_i;
            py_d    = y_pos_i;
            state_d = S_R2;
          end else if (mem_we) begin
            if (last_waypoint_i) begin
              len_d = 11'(waypoint_index_i) + 11'd1;
            end
            if ((waypoint_index_i == 10'd0) && !rdy_q) begin
              rdy_d  = 1'b1;
              slot_d = '0;
              tx_d   = x_pos_i;
              ty_d   = y_pos_i;
            end
          end
        end
      end
      S_R2:  state_d = S_M2;
      S_M2: begin
        r2_d    = mul_p[31:0];
        state_d = S_MM;
      end
      S_MM: begin
        mm2_d   = mul_p[31:0];
        state_d = S_ADV;
      end
      S_ADV: state_d = adv_ok ? S_DY : S_MX;
      S_DY: begin
        acc_d   = mul_p[SQ_W-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sum_sq < SQ_W'(r2_q)) begin
          slot_d  = slot_q + 10'd1;
          state_d = S_RD;
        end else begin
          state_d = S_MX;
        end
      end
      S_RD: begin
        tx_d    = mem_rdata[2*POS_W-1:POS_W];
        ty_d    = mem_rdata[POS_W-1:0];
        state_d = S_ADV;
      end
      S_MX:  state_d = S_MY;
      S_MY: begin
        acc_d   = mul_p[SQ_W-1:0];
        state_d = S_MCMP;
      end
      S_MCMP: begin
        cnt_d = '0;
        if (sum_sq > SQ_W'(mm2_q)) begin
          state_d = S_VEC;
        end else begin
          head_d  = prevh_q;
          state_d = S_ROTI;
        end
      end
      S_VEC: begin
        if (cnt_q == LAST_STEP) begin
          state_d = S_VEND;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_VEND: begin
        head_d  = cz[15:0];
        state_d = S_ROTI;
      end
      S_ROTI: begin
        cnt_d   = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        if (cnt_q == LAST_STEP) begin
          state_d = S_LAT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_LAT: state_d = S_LS;
      S_LS: begin
        if (lat_full > LAT_MAX) begin
          lat_d = 25'(LAT_MAX);
        end else if (lat_full < LAT_MIN) begin
          lat_d = 25'(LAT_MIN);
        end else begin
          lat_d = 25'(lat_full);
        end
        state_d = S_ST;
      end
      S_ST:  state_d = S_STC;
      S_STC: begin
        if (steer_full > lim) begin
          steer_d = 19'(lim);
        end else if (steer_full < -lim) begin
          steer_d = 19'(-lim);
        end else begin
          steer_d = 19'(steer_full);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          osteer_d = steer_q;
          ospeed_d = speed_q;
          oslot_d  = slot_q;
          ohead_d  = head_q;
          olat_d   = lat_q;
          prevx_d  = px_q;
          prevy_d  = py_q;
          prevh_d  = head_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      tx_q     <= '0;
      ty_q     <= '0;
      prevx_q  <= '0;
      prevy_q  <= '0;
      prevh_q  <= '0;
      slot_q   <= '0;
      len_q    <= '0;
      rdy_q    <= 1'b0;
      ovalid_q <= 1'b0;
      gain_q   <= 12'd640;
      limit_q  <= 18'd122880;
      reach_q  <= 16'd3277;
      min_q    <= 16'd205;
      speed_q  <= 16'd1024;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      tx_q     <= tx_d;
      ty_q     <= ty_d;
      prevx_q  <= prevx_d;
      prevy_q  <= prevy_d;
      prevh_q  <= prevh_d;
      slot_q   <= slot_d;
      len_q    <= len_d;
      rdy_q    <= rdy_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CFG_STEER_GAIN:   gain_q  <= cfg_data_i[11:0];
          CFG_STEER_LIMIT:  limit_q <= cfg_data_i;
          CFG_REACH_RADIUS: reach_q <= cfg_data_i[15:0];
          CFG_MIN_MOVE:     min_q   <= cfg_data_i[15:0];
          CFG_CRUISE_SPEED: speed_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    head_q   <= head_d;
    r2_q     <= r2_d;
    mm2_q    <= mm2_d;
    acc_q    <= acc_d;
    lat_q    <= lat_d;
    steer_q  <= steer_d;
    osteer_q <= osteer_d;
    ospeed_q <= ospeed_d;
    oslot_q  <= oslot_d;
    ohead_q  <= ohead_d;
    olat_q   <= olat_d;
  end

  wfs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  wfs_cordic u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (cctl),
    .step_i (cnt_q),
    .x_i    (cx_in),
    .y_i    (cy_in),
    .z_i    (cz_in),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz)
  );

  wfs_path_mem #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(waypoint_index_i)),
    .wdata_i ({x_pos_i, y_pos_i}),
    .re_i    (mem_re),
    .raddr_i (AW'(slot_q + 10'd1)),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o     = ovalid_q;
  assign steer_cmd_o     = osteer_q;
  assign speed_cmd_o     = ospeed_q;
  assign target_index_o  = oslot_q;
  assign heading_o       = ohead_q;
  assign lateral_error_o = olat_q;

  `WFS_ASSERT(a_rise_after_out, $rose(ovalid_q), $past(state_q == S_OUT))
  `WFS_ASSERT(a_cnt_bound, (state_q == S_VEC) || (state_q == S_ROT), cnt_q <= LAST_STEP)
  `WFS_ASSERT_NEXT(a_sample_starts, in_valid_i && in_ready_o && kind_i, state_q == S_R2)
  `WFS_ASSERT(a_slot_moves, slot_q != $past(slot_q), $past(state_q == S_CMP) || $past(state_q == S_IDLE))

endmodule

// ----- design/wfs_mul.sv -----
// Shared registered signed multiplier.
module wfs_mul import wfs_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;
  logic signed [MUL_P_W-1:0] p_d;

  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- design/wfs_cordic.sv -----
// Iterative CORDIC unit, one vectoring or rotation step per cycle.
module wfs_cordic import wfs_pkg::*; (
  input  logic                       clk_i,
  input  wfs_cordic_ctrl_t           ctrl_i,
  input  logic [4:0]                 step_i,
  input  logic signed [CORDIC_W-1:0] x_i,
  input  logic signed [CORDIC_W-1:0] y_i,
  input  logic signed [ANG_W-1:0]    z_i,
  output logic signed [CORDIC_W-1:0] x_o,
  output logic signed [CORDIC_W-1:0] y_o,
  output logic signed [ANG_W-1:0]    z_o
);

  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ANG_W-1:0]    z_q, z_d, at;
  logic                       dir;

  assign xs  = x_q >>> step_i;
  assign ys  = y_q >>> step_i;
  assign at  = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_lut(step_i)});
  assign dir = ctrl_i.vectoring ? y_q[CORDIC_W-1] : !z_q[ANG_W-1];

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      x_d = x_i;
      y_d = y_i;
      if (ctrl_i.vectoring) begin
        z_d = '0;
        if (x_i[CORDIC_W-1]) begin
          if (!y_i[CORDIC_W-1]) begin
            x_d = y_i;
            y_d = -x_i;
            z_d = ANG_QUARTER;
          end else begin
            x_d = -y_i;
            y_d = x_i;
            z_d = -ANG_QUARTER;
          end
        end
      end else begin
        z_d = z_i;
        if (z_i > ANG_QUARTER) begin
          x_d = -y_i;
          y_d = x_i;
          z_d = z_i - ANG_QUARTER;
        end else if (z_i < -ANG_QUARTER) begin
          x_d = y_i;
          y_d = -x_i;
          z_d = z_i + ANG_QUARTER;
        end
      end
    end else if (ctrl_i.step) begin
      if (dir) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- design/wfs_path_mem.sv -----
// Waypoint store: one write port, one registered read port.
module wfs_path_mem import wfs_pkg::*; #(
  parameter int unsigned PATH_DEPTH = 1024,
  localparam int unsigned AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [2*POS_W-1:0]   wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [2*POS_W-1:0]   rdata_o
);

  logic [2*POS_W-1:0] mem_q [PATH_DEPTH];
  logic [2*POS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
